// ===== rtl/mtf_pkg.sv =====
// shared types and codes for the move-to-front list
// no dependencies

package mtf_pkg;

   // item opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BAD_POS   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FILL,
      S_DONE
   } state_type;

   // field widths fixed by the interface
   localparam int unsigned POS_W = 7;
   localparam int unsigned VAL_W = 32;

endpackage

// ===== rtl/move_to_front_list.sv =====
// move-to-front list: ordered list of signed 32-bit values held in one memory
// depends on mtf_pkg

// The list lives in a single DEPTH x 32 synchronous memory (one write port,
// one read port, registered read). One item is worked at a time. An insert
// at position p into a list of n entries, p up to n, moves the n - p + 1
// entries from p to n back one place by a read/write pipeline that moves
// one entry per cycle, then the new value is written and the result is
// loaded. An append at position n + 1 moves nothing. A search that hits at
// position k reads and compares up to it, moves the k - 1 entries ahead of
// it back one place, writes the key at the front and loads the result; a
// hit at the front moves nothing and a miss reads every entry. Bad
// positions, full-list inserts and searches of an empty list go straight
// to the result. The result sits in an output register, so the next item
// is accepted while it waits; a finished item whose result finds that
// register still held waits for it to drain.
// entry_count is the number of entries after the item, low 7 bits.
module move_to_front_list #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [mtf_pkg::POS_W-1:0]   req_position,
   input  logic signed [mtf_pkg::VAL_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mtf_pkg::POS_W-1:0]   rsp_found_position,
   output logic [1:0]                  rsp_status,
   output logic [mtf_pkg::POS_W-1:0]   rsp_entry_count
);
   import mtf_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned XW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

   // entry memory
   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [VAL_W-1:0] wr_data;

   // control state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic chk_valid_ff, chk_valid_in;
   logic pend_ff, pend_in;
   logic issuing_ff, issuing_in;

   // item and working payload
   logic             op_ff, op_in;
   logic [VAL_W-1:0] key_ff, key_in;
   logic [AW-1:0]    lo_ff, lo_in;
   logic [AW-1:0]    src_ff, src_in;
   logic [AW-1:0]    dest_ff, dest_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [AW-1:0]    chk_idx_ff, chk_idx_in;
   logic [POS_W-1:0] res_found_ff, res_found_in;
   status_type       res_status_ff, res_status_in;
   logic [POS_W-1:0] rsp_found_ff, rsp_found_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0] rsp_count_ff, rsp_count_in;

   logic          accept;
   logic [XW-1:0] pos_x;
   logic [XW-1:0] lim_x;
   logic          hit;
   logic          last_chk;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign pos_x     = XW'(req_position);
   assign lim_x     = XW'(count_ff) + XW'(1);
   assign hit       = chk_valid_ff && (rd_data_ff == key_ff);
   assign last_chk  = (CW'(chk_idx_ff) == count_ff - CW'(1));

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_count    = rsp_count_ff;

   // memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         issuing_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_valid_ff <= chk_valid_in;
         pend_ff      <= pend_in;
         issuing_ff   <= issuing_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      src_ff        <= src_in;
      dest_ff       <= dest_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // sequencer: next state, memory control, result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      chk_valid_in  = chk_valid_ff;
      pend_in       = pend_ff;
      issuing_in    = issuing_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      lo_in         = lo_ff;
      src_in        = src_ff;
      dest_in       = dest_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = src_ff;
      wr_en         = 1'b0;
      wr_addr       = dest_ff;
      wr_data       = rd_data_ff;

      // result register drains independently
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in        = req_opcode;
               key_in       = req_value;
               res_found_in = '0;
               if (req_opcode == OP_INSERT) begin
                  lo_in = AW'(pos_x - XW'(1));
                  if (req_position == '0 || pos_x > lim_x) begin
                     res_status_in = ST_BAD_POS;
                     state_in      = S_DONE;
                  end else if (count_ff >= CW'(DEPTH)) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else if (pos_x == lim_x) begin
                     // append at the tail: nothing to move
                     res_status_in = ST_OK;
                     state_in      = S_FILL;
                  end else begin
                     res_status_in = ST_OK;
                     src_in        = AW'(count_ff - CW'(1));
                     issuing_in    = 1'b1;
                     pend_in       = 1'b0;
                     state_in      = S_SHIFT;
                  end
               end else begin
                  lo_in = '0;
                  if (count_ff == '0) begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     rd_idx_in    = '0;
                     chk_valid_in = 1'b0;
                     state_in     = S_SCAN;
                  end
               end
            end
         end

         S_SCAN: begin
            // compare the entry read last cycle, keep reading ahead
            if (hit) begin
               res_found_in  = POS_W'(CW'(chk_idx_ff) + CW'(1));
               res_status_in = ST_OK;
               chk_valid_in  = 1'b0;
               if (chk_idx_ff == '0) begin
                  state_in = S_FILL;
               end else begin
                  src_in     = chk_idx_ff - AW'(1);
                  issuing_in = 1'b1;
                  pend_in    = 1'b0;
                  state_in   = S_SHIFT;
               end
            end else if (chk_valid_ff && last_chk) begin
               res_status_in = ST_NOT_FOUND;
               chk_valid_in  = 1'b0;
               state_in      = S_DONE;
            end else begin
               rd_addr      = rd_idx_ff[AW-1:0];
               rd_en        = (rd_idx_ff < count_ff);
               chk_valid_in = rd_en;
               chk_idx_in   = rd_idx_ff[AW-1:0];
               rd_idx_in    = rd_idx_ff + CW'(1);
            end
         end

         S_SHIFT: begin
            // write back the entry read last cycle one place later
            wr_en = pend_ff;
            if (issuing_ff) begin
               rd_addr = src_ff;
               rd_en   = 1'b1;
               pend_in = 1'b1;
               dest_in = src_ff + AW'(1);
               if (src_ff == lo_ff) begin
                  issuing_in = 1'b0;
               end else begin
                  src_in = src_ff - AW'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_FILL;
               end
            end
         end

         S_FILL: begin
            // new value or found key goes into the gap
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = key_ff;
            if (op_ff == OP_INSERT) begin
               count_in = count_ff + CW'(1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = POS_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== test/tb.sv =====
// testbench for move_to_front_list: directed and random insert/search items
// checked against a queue-based model of the list; depends on mtf_pkg and the rtl
`timescale 1ns / 1ps

module tb;
   import mtf_pkg::*;

   localparam int LIST_DEPTH     = 64;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 160;
   localparam int MAX_PRINTS     = 40;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [POS_W-1:0] found_position;
      status_type       status;
      logic [POS_W-1:0] entry_count;
   } list_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_opcode;
   logic [POS_W-1:0]        req_position;
   logic signed [VAL_W-1:0] req_value;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [POS_W-1:0]        rsp_found_position;
   logic [1:0]              rsp_status;
   logic [POS_W-1:0]        rsp_entry_count;

   // model of the list contents, front first
   logic signed [VAL_W-1:0] list_model[$];
   // results owed by the block, oldest first
   list_result_type         pending_results[$];

   int error_count   = 0;
   int hold_requests = 0;
   int burst_left    = 0;
   int gap_before_burst = 1;
   int stall_cycles  = 0;

   move_to_front_list #(
      .DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endtask

   // apply one item to the list model and return the result it should give
   function automatic list_result_type apply_to_list(input logic op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [VAL_W-1:0] val);
      list_result_type res;
      int              count;
      count = list_model.size();
      res.found_position = '0;
      res.status = ST_OK;
      if (op == OP_INSERT) begin
         if (pos == 0 || int'(pos) > count + 1) begin
            res.status = ST_BAD_POS;
         end else if (count >= LIST_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            list_model.insert(int'(pos) - 1, val);
         end
      end else begin
         res.status = ST_NOT_FOUND;
         for (int i = 0; i < count; i++) begin
            if (list_model[i] == val) begin
               list_model.delete(i);
               list_model.push_front(val);
               res.found_position = POS_W'(i + 1);
               res.status = ST_OK;
               break;
            end
         end
      end
      res.entry_count = POS_W'(list_model.size());
      return res;
   endfunction

   // offer one item, wait for it to be taken, then book its expected result
   task automatic send_item(input logic op, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val);
      if (burst_left == 0) begin
         repeat (gap_before_burst) @(posedge clock);
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_to_list(op, pos, val));
      burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap_before_burst = ($urandom_range(9) < 3) ? 1 : $urandom_range(1, 12);
      end
   endtask

   // drop valid between items when the sender has to stop
   task automatic idle_sender();
      if (burst_left != 0) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_before_burst = 1;
      end
   endtask

   task automatic wait_all_results();
      idle_sender();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // values drawn from a small pool make duplicates likely
   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] pool[8];
      pool = '{32'sd0, 32'sd1, -32'sd1, 32'sd2, 32'sd3, VAL_MIN, VAL_MAX, 32'sd7};
      if ($urandom_range(3) == 0) begin
         return pool[$urandom_range(7)];
      end
      return $urandom;
   endfunction

   // one random item shaped by the current list length
   task automatic send_random_item(input int insert_pct);
      int               count;
      int               top_pos;
      logic [POS_W-1:0] pos;
      logic signed [VAL_W-1:0] val;
      count = list_model.size();
      top_pos = (count + 1 > LIST_DEPTH) ? LIST_DEPTH : count + 1;
      if ($urandom_range(99) < insert_pct) begin
         if ($urandom_range(3) != 0) begin
            // legal position, ends favored
            case ($urandom_range(3))
               0: pos = POS_W'(1);
               1: pos = POS_W'(top_pos);
               default: pos = POS_W'($urandom_range(1, top_pos));
            endcase
         end else if (count <= LIST_DEPTH - 2 && $urandom_range(1) == 1) begin
            pos = POS_W'($urandom_range(count + 2, LIST_DEPTH));
         end else begin
            pos = '0;
         end
         send_item(OP_INSERT, pos, pick_value());
      end else begin
         if (count > 0 && $urandom_range(9) < 6) begin
            val = list_model[$urandom_range(0, count - 1)];
         end else begin
            val = pick_value();
         end
         send_item(OP_SEARCH, POS_W'($urandom_range(0, LIST_DEPTH)), val);
      end
   endtask

   // field extremes, bad positions, duplicates, hits at front/middle/back, misses
   task automatic test_directed();
      send_item(OP_SEARCH, 7'd0, 32'sd0);          // empty list
      send_item(OP_INSERT, 7'd0, 32'sd9);          // position zero
      send_item(OP_INSERT, 7'd2, 32'sd9);          // past end of empty list
      send_item(OP_INSERT, 7'd64, 32'sd9);
      send_item(OP_INSERT, 7'd1, VAL_MIN);
      send_item(OP_INSERT, 7'd2, VAL_MAX);         // append
      send_item(OP_INSERT, 7'd1, 32'sd0);          // front
      send_item(OP_INSERT, 7'd2, -32'sd1);         // middle
      send_item(OP_INSERT, 7'd6, 32'sd7);          // one past count+1
      send_item(OP_INSERT, 7'd5, 32'sd5);
      send_item(OP_INSERT, 7'd1, 32'sd5);          // duplicate at front
      send_item(OP_SEARCH, 7'd0, 32'sd5);
      send_item(OP_SEARCH, 7'd3, VAL_MAX);
      send_item(OP_SEARCH, 7'd0, VAL_MIN);
      send_item(OP_SEARCH, 7'd0, 32'sd12345);      // miss
      send_item(OP_INSERT, 7'd4, 32'sd5);
      send_item(OP_SEARCH, 7'd0, -32'sd1);
      send_item(OP_SEARCH, 7'd0, 32'sd5);          // first of the duplicates
      send_item(OP_INSERT, 7'd1, 32'sh5555_5555);
      send_item(OP_INSERT, 7'd9, 32'shaaaa_aaaa);
      send_item(OP_SEARCH, 7'd0, 32'shaaaa_aaaa);  // last entry
      send_item(OP_SEARCH, 7'd64, 32'sd0);         // position ignored on search
      wait_all_results();
   endtask

   // the full list case is reached here once enough inserts have landed
   task automatic test_random(input int n_items, input int insert_pct);
      for (int n = 0; n < n_items; n++) begin
         send_random_item(insert_pct);
      end
   endtask

   // receiver holds off while items keep coming, then the sender drains
   task automatic test_backpressure();
      hold_requests++;
      for (int n = 0; n < 30; n++) begin
         send_random_item(40);
      end
      wait_all_results();
   endtask

   // receiver: random modes with a long hold on request
   initial begin : rsp_side
      int          mode;
      int          left;
      int          hold_left;
      int          served;
      logic [15:0] pattern;
      rsp_ready = 1'b0;
      mode = 0;
      left = 0;
      hold_left = 0;
      served = 0;
      pattern = '1;
      forever begin
         @(posedge clock);
         if (served < hold_requests) begin
            served++;
            hold_left = LONG_HOLD;
         end
         if (left == 0) begin
            mode = $urandom_range(2);
            left = $urandom_range(16, 80);
            pattern = 16'($urandom);
         end
         left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(1));
               default: begin
                  rsp_ready <= pattern[0];
                  pattern = {pattern[0], pattern[15:1]};
               end
            endcase
         end
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no item outstanding: pos %0d status %0d count %0d",
                                      rsp_found_position, rsp_status, rsp_entry_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_found_position !== want.found_position) begin
               report_mismatch($sformatf("found_position %0d, want %0d",
                                         rsp_found_position, want.found_position));
            end
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %s", rsp_status, want.status.name()));
            end
            if (rsp_entry_count !== want.entry_count) begin
               report_mismatch($sformatf("entry_count %0d, want %0d",
                                         rsp_entry_count, want.entry_count));
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_opcode   = OP_INSERT;
      req_position = '0;
      req_value    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(350, 45);
      test_backpressure();
      test_random(350, 30);

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
